FILE: rtl/rspt_pkg.sv
// Shared types, codes and constants of the ramp/soak profile thermostat.
package rspt_pkg;

   // Profile table size
   localparam int MAX_STEPS  = 16;
   localparam int STEP_IDX_W = (MAX_STEPS > 1) ? $clog2(MAX_STEPS) : 1;
   localparam int STEP_CNT_W = $clog2(MAX_STEPS + 1);

   // Field widths
   localparam int TEMP_W    = 12;
   localparam int HOLD_S_W  = 16;
   localparam int HOLD_MS_W = 26;
   localparam int TOTAL_W   = 32;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 12;

   localparam logic [9:0]            MS_PER_S   = 10'd1000;
   localparam logic [HOLD_MS_W-1:0]  HOLD_MAX   = '1;
   localparam logic [TOTAL_W-1:0]    TOTAL_MAX  = '1;

   // Reset values of run state and registers
   localparam logic signed [TEMP_W-1:0] TEMP_RESET = 12'sd220;
   localparam logic [7:0]               HYST_RESET = 8'd5;
   localparam logic [7:0]               BAND_RESET = 8'd3;
   localparam logic signed [TEMP_W-1:0] OVER_RESET = 12'sd1050;

   // Operation codes
   localparam logic [1:0] FUNC_TICK  = 2'd0;
   localparam logic [1:0] FUNC_START = 2'd1;
   localparam logic [1:0] FUNC_STOP  = 2'd2;
   localparam logic [1:0] FUNC_LOAD  = 2'd3;

   // Run modes
   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_RUN  = 2'd1;
   localparam logic [1:0] MODE_DONE = 2'd2;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_HYSTERESIS = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_NEAR_BAND  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OVER_LIMIT = 2'd2;

   typedef struct packed {
      logic [1:0]               func;
      logic [15:0]              tick_ms;
      logic                     sample_valid;
      logic signed [TEMP_W-1:0] sample_temp;
      logic [3:0]               load_index;
      logic signed [TEMP_W-1:0] load_temp;
      logic [HOLD_S_W-1:0]      load_hold_s;
      logic                     load_last;
   } req_type;

   typedef struct packed {
      logic                     heater;
      logic [1:0]               run_mode;
      logic [4:0]               active_step;
      logic signed [TEMP_W-1:0] target_temp;
      logic signed [TEMP_W-1:0] present_temp;
      logic [HOLD_MS_W-1:0]     hold_elapsed_ms;
      logic [TOTAL_W-1:0]       total_elapsed_ms;
      logic                     over_temp;
      logic                     accepted;
   } rsp_type;

   typedef struct packed {
      logic [7:0]               hysteresis;
      logic [7:0]               near_band;
      logic signed [TEMP_W-1:0] over_limit;
   } cfg_type;

   typedef struct packed {
      logic [1:0]               mode;
      logic [STEP_CNT_W-1:0]    total;
      logic [STEP_CNT_W-1:0]    ptr;
      logic signed [TEMP_W-1:0] target;
      logic signed [TEMP_W-1:0] temp;
      logic                     heater;
      logic                     reached;
      logic [HOLD_MS_W-1:0]     hold;
      logic [TOTAL_W-1:0]       total_acc;
   } state_type;

   // Profile table write port
   typedef struct packed {
      logic                     we;
      logic [STEP_IDX_W-1:0]    idx;
      logic signed [TEMP_W-1:0] temp;
      logic [HOLD_MS_W-1:0]     hold_ms;
   } step_wr_type;

endpackage

FILE: rtl/rspt_table.sv
// Profile step storage: target temperature and hold time in ms per slot.
module rspt_table import rspt_pkg::*; (
   input  logic                     clock,
   input  step_wr_type              wr,
   input  logic [STEP_IDX_W-1:0]    rd_idx,
   output logic signed [TEMP_W-1:0] rd_temp,
   output logic [HOLD_MS_W-1:0]     rd_hold_ms,
   output logic signed [TEMP_W-1:0] step0_temp
);

   logic signed [TEMP_W-1:0] temps_ff [MAX_STEPS];
   logic [HOLD_MS_W-1:0]     holds_ff [MAX_STEPS];

   // Slots are undefined until loaded, so no reset
   always_ff @(posedge clock) begin
      if (wr.we) begin
         temps_ff[wr.idx] <= wr.temp;
         holds_ff[wr.idx] <= wr.hold_ms;
      end
   end

   assign rd_temp    = temps_ff[rd_idx];
   assign rd_hold_ms = holds_ff[rd_idx];
   assign step0_temp = temps_ff[0];

endmodule

FILE: rtl/rspt_step.sv
// Next-state and result logic for one operation.
module rspt_step import rspt_pkg::*; (
   input  req_type                  req,
   input  state_type                st,
   input  cfg_type                  cfg,
   input  logic signed [TEMP_W-1:0] rd_temp,
   input  logic [HOLD_MS_W-1:0]     rd_hold_ms,
   input  logic signed [TEMP_W-1:0] step0_temp,
   output state_type                nxt,
   output step_wr_type              wr,
   output rsp_type                  res
);

   logic signed [13:0]     temp_x;
   logic signed [13:0]     tgt_x;
   logic signed [13:0]     on_thr;
   logic signed [13:0]     new_tgt_x;
   logic signed [13:0]     reach_thr;
   logic [TOTAL_W:0]       total_sum;
   logic [HOLD_MS_W:0]     hold_sum;
   logic [STEP_CNT_W-1:0]  ptr_inc;
   logic                   idx_ok;
   logic                   over;
   logic                   acc;

   // Thresholds, all in sign-extended tenths of a degree
   assign temp_x    = 14'(st.temp);
   assign tgt_x     = 14'(st.target);
   assign on_thr    = tgt_x - $signed({6'b0, cfg.hysteresis});
   assign new_tgt_x = 14'(rd_temp);
   assign reach_thr = new_tgt_x - $signed({6'b0, cfg.near_band});
   assign total_sum = {1'b0, st.total_acc} + (TOTAL_W + 1)'(req.tick_ms);
   assign hold_sum  = {1'b0, st.hold} + (HOLD_MS_W + 1)'(req.tick_ms);
   assign ptr_inc   = st.ptr + STEP_CNT_W'(1);
   assign idx_ok    = 32'(req.load_index) < MAX_STEPS;

   // Table write for a load with an index in range
   always_comb begin
      wr.we      = (req.func == FUNC_LOAD) && idx_ok;
      wr.idx     = STEP_IDX_W'(req.load_index);
      wr.temp    = req.load_temp;
      wr.hold_ms = HOLD_MS_W'(req.load_hold_s) * HOLD_MS_W'(MS_PER_S);
   end

   always_comb begin
      nxt  = st;
      over = 1'b0;
      acc  = 1'b1;
      case (req.func)
         FUNC_TICK: begin
            if (st.mode == MODE_RUN) begin
               // hysteresis thermostat on the stored temperature and target
               if (temp_x <= on_thr) begin
                  nxt.heater = 1'b1;
               end else if (temp_x >= tgt_x) begin
                  nxt.heater = 1'b0;
               end
               // profile advance
               if (st.ptr >= st.total || st.ptr >= STEP_CNT_W'(MAX_STEPS)) begin
                  nxt.mode   = MODE_DONE;
                  nxt.heater = 1'b0;
               end else begin
                  nxt.total_acc = total_sum[TOTAL_W] ? TOTAL_MAX : total_sum[TOTAL_W-1:0];
                  nxt.target    = rd_temp;
                  nxt.reached   = st.reached || (temp_x >= reach_thr);
                  if (nxt.reached) begin
                     nxt.hold = hold_sum[HOLD_MS_W] ? HOLD_MAX : hold_sum[HOLD_MS_W-1:0];
                     if (nxt.hold >= rd_hold_ms) begin
                        nxt.ptr     = ptr_inc;
                        nxt.hold    = '0;
                        nxt.reached = 1'b0;
                        if (ptr_inc >= st.total) begin
                           nxt.mode   = MODE_DONE;
                           nxt.heater = 1'b0;
                        end
                     end
                  end
               end
            end else begin
               nxt.heater = 1'b0;
            end
            // sensor sample and over-temperature cutoff
            if (req.sample_valid) begin
               nxt.temp = req.sample_temp;
               if (req.sample_temp >= cfg.over_limit) begin
                  over       = 1'b1;
                  nxt.heater = 1'b0;
               end
            end
         end
         FUNC_START: begin
            if (st.total != '0) begin
               nxt.mode      = MODE_RUN;
               nxt.ptr       = '0;
               nxt.hold      = '0;
               nxt.total_acc = '0;
               nxt.reached   = 1'b0;
               nxt.heater    = 1'b0;
               nxt.target    = step0_temp;
            end else begin
               acc = 1'b0;
            end
         end
         FUNC_STOP: begin
            nxt.mode   = MODE_IDLE;
            nxt.heater = 1'b0;
         end
         default: begin
            // load; the last mark sets the count and rewinds the run
            if (!idx_ok) begin
               acc = 1'b0;
            end else if (req.load_last) begin
               nxt.total     = STEP_CNT_W'(32'(req.load_index) + 32'd1);
               nxt.mode      = MODE_IDLE;
               nxt.ptr       = '0;
               nxt.hold      = '0;
               nxt.total_acc = '0;
               nxt.reached   = 1'b0;
               nxt.heater    = 1'b0;
               nxt.target    = (req.load_index == 4'd0) ? req.load_temp : step0_temp;
            end
         end
      endcase
   end

   // Result reflects the state after this operation
   always_comb begin
      res.heater           = nxt.heater;
      res.run_mode         = nxt.mode;
      res.active_step      = 5'(nxt.ptr);
      res.target_temp      = nxt.target;
      res.present_temp     = nxt.temp;
      res.hold_elapsed_ms  = nxt.hold;
      res.total_elapsed_ms = nxt.total_acc;
      res.over_temp        = over;
      res.accepted         = acc;
   end

endmodule

FILE: rtl/ramp_soak_profile_thermostat.sv
// Top level: request register, run state, configuration and result register.
//
// Ramp/soak profile thermostat. Each request (tick, start, stop or profile load)
// produces exactly one response. One request is taken every clock cycle unless
// the request side is stalled; a request is held in the request register, and
// the whole update of the run state is done in one pass of logic from there into
// the response register. The run state is written back with each processed
// request, so back-to-back requests see each other's effects in order. A stalled
// response holds the request register, which then stalls the request side.
// Configuration writes take effect on the next cycle and are meant for idle time.
module ramp_soak_profile_thermostat import rspt_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  req_type              req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output rsp_type              rsp_data,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_wdata
);

   logic                     in_valid_ff, in_valid_in;
   req_type                  in_ff;
   logic                     out_valid_ff, out_valid_in;
   rsp_type                  out_ff;
   state_type                state_ff, state_in;
   cfg_type                  cfg_ff, cfg_in;
   state_type                nxt;
   step_wr_type              wr;
   step_wr_type              tbl_wr;
   rsp_type                  res;
   logic signed [TEMP_W-1:0] rd_temp;
   logic [HOLD_MS_W-1:0]     rd_hold_ms;
   logic signed [TEMP_W-1:0] step0_temp;
   logic                     out_take;
   logic                     proc;
   logic                     req_xfer;

   // Handshake: the response register frees when empty or taken
   assign out_take  = !out_valid_ff || !rsp_stall;
   assign proc      = in_valid_ff && out_take;
   assign req_stall = in_valid_ff && !out_take;
   assign req_xfer  = req_valid && !req_stall;

   assign in_valid_in  = req_xfer || (in_valid_ff && !proc);
   assign out_valid_in = proc || (out_valid_ff && rsp_stall);
   assign state_in     = proc ? nxt : state_ff;

   // Configuration register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_HYSTERESIS: cfg_in.hysteresis = csr_wdata[7:0];
            CSR_NEAR_BAND:  cfg_in.near_band  = csr_wdata[7:0];
            CSR_OVER_LIMIT: cfg_in.over_limit = $signed(csr_wdata[TEMP_W-1:0]);
            default: ;
         endcase
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff        <= 1'b0;
         out_valid_ff       <= 1'b0;
         state_ff.mode      <= MODE_IDLE;
         state_ff.total     <= '0;
         state_ff.ptr       <= '0;
         state_ff.target    <= '0;
         state_ff.temp      <= TEMP_RESET;
         state_ff.heater    <= 1'b0;
         state_ff.reached   <= 1'b0;
         state_ff.hold      <= '0;
         state_ff.total_acc <= '0;
         cfg_ff.hysteresis  <= HYST_RESET;
         cfg_ff.near_band   <= BAND_RESET;
         cfg_ff.over_limit  <= OVER_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         state_ff     <= state_in;
         cfg_ff       <= cfg_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         in_ff <= req_data;
      end
      if (proc) begin
         out_ff <= res;
      end
   end

   always_comb begin
      tbl_wr    = wr;
      tbl_wr.we = wr.we && proc;
   end

   rspt_table u_table (
      .clock      (clock),
      .wr         (tbl_wr),
      .rd_idx     (state_ff.ptr[STEP_IDX_W-1:0]),
      .rd_temp    (rd_temp),
      .rd_hold_ms (rd_hold_ms),
      .step0_temp (step0_temp)
   );

   rspt_step u_step (
      .req        (in_ff),
      .st         (state_ff),
      .cfg        (cfg_ff),
      .rd_temp    (rd_temp),
      .rd_hold_ms (rd_hold_ms),
      .step0_temp (step0_temp),
      .nxt        (nxt),
      .wr         (wr),
      .res        (res)
   );

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   // The step pointer never runs past the loaded step count
   a_ptr_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff.ptr <= state_ff.total)
      else $error("step pointer beyond step count");

   // The heater is only driven while a profile runs
   a_heater_run: assert property (@(posedge clock) disable iff (reset)
      state_ff.mode != MODE_RUN |-> !state_ff.heater)
      else $error("heater on outside run mode");

   // Hold time accumulates only after the step target was reached
   a_hold_reached: assert property (@(posedge clock) disable iff (reset)
      state_ff.hold != '0 |-> state_ff.reached)
      else $error("hold time without reached step");

   // A processed request always leaves a response behind
   a_proc_rsp: assert property (@(posedge clock) disable iff (reset)
      proc |=> rsp_valid)
      else $error("processed request lost its response");

endmodule
